FILE: rtl/core/radix_digit_formatter_defines.svh
// Assertion macros used by the formatter top level.
`ifndef RADIX_DIGIT_FORMATTER_DEFINES_SVH
`define RADIX_DIGIT_FORMATTER_DEFINES_SVH

// Same-cycle implication.
`define RDF_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define RDF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/rdf_pkg.sv
package rdf_pkg;

   localparam int MAX_DIGITS_DEFAULT = 32;

   localparam logic [1:0] MODE_BIN = 2'd0;
   localparam logic [1:0] MODE_OCT = 2'd1;
   localparam logic [1:0] MODE_HEX = 2'd2;
   localparam logic [1:0] MODE_DEC = 2'd3;

   typedef struct packed {
      logic signed [31:0] value;
      logic [1:0]         action;
   } rdf_req_type;

   typedef struct packed {
      logic [3:0] digit;
      logic [6:0] ascii_code;
      logic [4:0] position;
      logic       no_digits;
      logic       last;
   } rdf_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ZERO,
      ST_STEP,
      ST_DSUB,
      ST_PRIME,
      ST_EMIT
   } rdf_state_type;

   typedef struct packed {
      logic load;
      logic shift_step;
      logic mul_step;
      logic sub_step;
      logic emit_start;
      logic emit_digit;
      logic emit_none;
   } rdf_cmd_type;

   typedef struct packed {
      logic req_nonpos;
      logic quot_zero;
      logic full;
      logic decimal;
      logic last_digit;
      logic out_free;
   } rdf_status_type;

endpackage

FILE: rtl/core/radix_digit_formatter.sv
// Radix digit formatter.
// Input channel req_: one transfer carries a signed 32-bit value and a radix
// select (binary, octal, hex, decimal BCD). Output channel rsp_: one transfer
// per digit, with ascii code, position and a last flag. Binary, octal and hex
// digits come most significant first; BCD digits least significant first.
// A value of zero or less gives a single transfer flagged no_digits.
// A power-of-two radix splits digits with one shift per cycle; decimal
// takes a reciprocal multiply, then a subtract, for each digit.
// A prime step starts the digit RAM read, then one digit leaves per cycle
// while the output register is free. req_stall is high from the accepting
// edge until the last digit is loaded into the output register, so the next
// item can start while that digit still waits for the receiver.
// When rsp_stall is high the output register holds and the digit sequencer
// waits. Reset clears the controller and output valid; the digit RAM needs no
// clearing since every entry read was written by the same item.
`include "radix_digit_formatter_defines.svh"

module radix_digit_formatter #(
   parameter int MAX_DIGITS = rdf_pkg::MAX_DIGITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  rdf_pkg::rdf_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rdf_pkg::rdf_rsp_type rsp_data
);
   import rdf_pkg::*;

   rdf_cmd_type    cmd;
   rdf_status_type status;

   rdf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rdf_dpath #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   `RDF_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && !req_stall, req_stall, "block took a req transfer but was not busy after it")
   `RDF_ASSERT_IMPLY(a_none_is_last, clock, reset, rsp_valid && rsp_data.no_digits, rsp_data.last && (rsp_data.position == 5'd0), "no_digits result not a single last result")
   `RDF_ASSERT_IMPLY(a_no_req_mid_seq, clock, reset, rsp_valid && !rsp_data.last, req_stall, "req accepted while digits of an earlier item remain")

endmodule

FILE: rtl/core/rdf_ram.sv
module rdf_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/rdf_ctrl.sv
module rdf_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  rdf_pkg::rdf_status_type status,
   output rdf_pkg::rdf_cmd_type    cmd
);
   import rdf_pkg::*;

   rdf_state_type state_ff;
   rdf_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = status.req_nonpos ? ST_ZERO : ST_STEP;
            end
         end
         ST_ZERO: begin
            if (status.out_free) begin
               cmd.emit_none = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_STEP: begin
            if (status.quot_zero || status.full) begin
               state_in = ST_PRIME;
            end else if (status.decimal) begin
               cmd.mul_step = 1'b1;
               state_in     = ST_DSUB;
            end else begin
               cmd.shift_step = 1'b1;
            end
         end
         ST_DSUB: begin
            cmd.sub_step = 1'b1;
            state_in     = ST_STEP;
         end
         ST_PRIME: begin
            cmd.emit_start = 1'b1;
            state_in       = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit_digit = 1'b1;
               if (status.last_digit) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/core/rdf_dpath.sv
module rdf_dpath #(
   parameter int MAX_DIGITS = rdf_pkg::MAX_DIGITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  rdf_pkg::rdf_cmd_type    cmd,
   input  rdf_pkg::rdf_req_type    req_data,
   input  logic                    rsp_stall,
   output rdf_pkg::rdf_status_type status,
   output logic                    rsp_valid,
   output rdf_pkg::rdf_rsp_type    rsp_data
);
   import rdf_pkg::*;

   localparam int LIMIT = (MAX_DIGITS < 31) ? MAX_DIGITS : 31;
   localparam int AW    = $clog2(LIMIT);
   localparam int CW    = $clog2(LIMIT + 1);
   localparam int DEPTH = 1 << AW;
   localparam logic [62:0] RECIP = 63'h0000_0000_CCCC_CCCD;

   function automatic logic [6:0] ascii_of(input logic [3:0] d);
      logic [6:0] dx;
      dx = {3'b000, d};
      return (d < 4'd10) ? (dx + 7'd48) : (dx + 7'd55);
   endfunction

   logic [30:0]   quot_ff, quot_in;
   logic [1:0]    mode_ff, mode_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [62:0]   prod_ff, prod_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rdf_rsp_type   rsp_data_ff, rsp_data_in;

   logic [3:0]    shift_digit;
   logic [30:0]   shift_quot;
   logic [27:0]   dec_quot;
   logic [30:0]   dec_quot10;
   logic [30:0]   dec_rem;
   logic          wr_en;
   logic [3:0]    wr_data;
   logic [CW-1:0] rev_idx;
   logic [AW-1:0] rd_addr;
   logic [3:0]    rd_data;
   logic          out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         idx_ff       <= '0;
         mode_ff      <= MODE_BIN;
         quot_ff      <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         mode_ff      <= mode_in;
         quot_ff      <= quot_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      case (mode_ff)
         MODE_OCT: begin
            shift_digit = {1'b0, quot_ff[2:0]};
            shift_quot  = quot_ff >> 3;
         end
         MODE_HEX: begin
            shift_digit = quot_ff[3:0];
            shift_quot  = quot_ff >> 4;
         end
         default: begin
            shift_digit = {3'b000, quot_ff[0]};
            shift_quot  = quot_ff >> 1;
         end
      endcase
   end

   assign dec_quot   = prod_ff[62:35];
   assign dec_quot10 = 31'({dec_quot, 3'b000}) + 31'({dec_quot, 1'b0});
   assign dec_rem    = quot_ff - dec_quot10;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      quot_in      = quot_ff;
      mode_in      = mode_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_data      = shift_digit;

      if (cmd.load) begin
         quot_in  = req_data.value[30:0];
         mode_in  = req_data.action;
         count_in = '0;
      end
      if (cmd.shift_step) begin
         wr_en    = 1'b1;
         quot_in  = shift_quot;
         count_in = count_ff + CW'(1);
      end
      if (cmd.mul_step) begin
         prod_in = 63'(quot_ff) * RECIP;
      end
      if (cmd.sub_step) begin
         wr_en    = 1'b1;
         wr_data  = dec_rem[3:0];
         quot_in  = 31'(dec_quot);
         count_in = count_ff + CW'(1);
      end
      if (cmd.emit_start) begin
         idx_in = '0;
      end
      if (cmd.emit_digit) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.digit      = rd_data;
         rsp_data_in.ascii_code = ascii_of(rd_data);
         rsp_data_in.position   = 5'(idx_ff);
         rsp_data_in.no_digits  = 1'b0;
         rsp_data_in.last       = (idx_ff + CW'(1)) == count_ff;
         idx_in                 = idx_ff + CW'(1);
      end
      if (cmd.emit_none) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.digit      = '0;
         rsp_data_in.ascii_code = '0;
         rsp_data_in.position   = '0;
         rsp_data_in.no_digits  = 1'b1;
         rsp_data_in.last       = 1'b1;
      end
   end

   // read address follows the next index so rd_data matches idx_ff during emission
   assign rev_idx = count_ff - CW'(1) - idx_in;
   assign rd_addr = (mode_ff == MODE_DEC) ? idx_in[AW-1:0] : rev_idx[AW-1:0];

   rdf_ram #(
      .WIDTH (4),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      status.req_nonpos = req_data.value[31] || (req_data.value == '0);
      status.quot_zero  = quot_ff == '0;
      status.full       = count_ff == CW'(LIMIT);
      status.decimal    = mode_ff == MODE_DEC;
      status.last_digit = (idx_ff + CW'(1)) == count_ff;
      status.out_free   = out_free;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: tb/rdf_digit_checker.sv
`timescale 1ns / 100ps

module rdf_digit_checker #(
   parameter int MAX_DIGITS = rdf_pkg::MAX_DIGITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  rdf_pkg::rdf_req_type req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  rdf_pkg::rdf_rsp_type rsp_data,
   output int                   error_count,
   output int                   pending_count
);
   import rdf_pkg::*;

   localparam int DIGIT_LIMIT = (MAX_DIGITS < 31) ? MAX_DIGITS : 31;
   localparam logic [6:0] ASCII_NUM_BASE = 7'd48;
   localparam logic [6:0] ASCII_ALPHA_BASE = 7'd55;

   rdf_rsp_type expected_digits[$];
   rdf_rsp_type want;

   function automatic int unsigned radix_of(input logic [1:0] mode);
      case (mode)
         MODE_BIN: return 2;
         MODE_OCT: return 8;
         MODE_HEX: return 16;
         default:  return 10;
      endcase
   endfunction

   function automatic void predict_digits(input rdf_req_type item);
      logic [3:0]  produced[0:31];
      int unsigned quot;
      int unsigned radix;
      int          count;
      int          src;
      rdf_rsp_type r;
      count = 0;
      if (item.value[31] || item.value == '0) begin
         r = '0;
         r.no_digits = 1'b1;
         r.last = 1'b1;
         expected_digits.push_back(r);
         return;
      end
      radix = radix_of(item.action);
      quot = int'(item.value[30:0]);
      while (quot != 0 && count < DIGIT_LIMIT) begin
         produced[count] = 4'(quot % radix);
         quot = quot / radix;
         count++;
      end
      for (int i = 0; i < count; i++) begin
         // decimal goes out least significant first, the others most significant first
         src = (item.action == MODE_DEC) ? i : count - 1 - i;
         r.digit = produced[src];
         r.ascii_code = (r.digit < 4'd10) ? 7'(r.digit) + ASCII_NUM_BASE
                                          : 7'(r.digit) + ASCII_ALPHA_BASE;
         r.position = 5'(i);
         r.no_digits = 1'b0;
         r.last = (i == count - 1);
         expected_digits.push_back(r);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         expected_digits.delete();
         error_count <= 0;
         pending_count <= 0;
      end else begin
         if (req_valid && !req_stall)
            predict_digits(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (expected_digits.size() == 0) begin
               error_count <= error_count + 1;
               $display("%0t: unexpected transfer digit=%0d ascii=%0d pos=%0d none=%b last=%b",
                        $time, rsp_data.digit, rsp_data.ascii_code, rsp_data.position,
                        rsp_data.no_digits, rsp_data.last);
            end else begin
               want = expected_digits.pop_front();
               if (rsp_data.digit !== want.digit || rsp_data.ascii_code !== want.ascii_code ||
                   rsp_data.position !== want.position ||
                   rsp_data.no_digits !== want.no_digits || rsp_data.last !== want.last) begin
                  error_count <= error_count + 1;
                  $display("%0t: mismatch exp digit=%0d ascii=%0d pos=%0d none=%b last=%b",
                           $time, want.digit, want.ascii_code, want.position,
                           want.no_digits, want.last,
                           " got digit=%0d ascii=%0d pos=%0d none=%b last=%b",
                           rsp_data.digit, rsp_data.ascii_code, rsp_data.position,
                           rsp_data.no_digits, rsp_data.last);
               end
            end
         end
         pending_count <= expected_digits.size();
      end
   end

endmodule

FILE: tb/tb_radix_digit_formatter.sv
`timescale 1ns / 100ps

module tb_radix_digit_formatter;
   import rdf_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES = 100;
   localparam int PHASE_ITEMS = 160;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   rdf_req_type req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rdf_rsp_type rsp_data;
   int          error_count;
   int          pending_count;
   int          send_idle_pct = 24;
   int          recv_stall_pct = 82;
   int          quiet_cycles;

   radix_digit_formatter i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   rdf_digit_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic send_item(input logic signed [31:0] value, input logic [1:0] mode);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{value: value, action: mode};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic send_random();
      logic [31:0] mask;
      logic [31:0] val;
      int unsigned width;
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 5) begin
         val = '0;
      end else if (roll < 12) begin
         val = $urandom | 32'h8000_0000;
      end else begin
         width = $urandom_range(31, 1);
         mask = (32'h1 << width) - 32'h1;
         val = ($urandom & mask) | (32'h1 << (width - 1));
      end
      send_item(val, 2'($urandom_range(3)));
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_item(0, MODE_BIN);
      send_item(0, MODE_OCT);
      send_item(0, MODE_HEX);
      send_item(0, MODE_DEC);
      send_item(-1, MODE_BIN);
      send_item(32'sh8000_0000, MODE_HEX);
      send_item(1, MODE_BIN);
      send_item(1, MODE_OCT);
      send_item(1, MODE_HEX);
      send_item(1, MODE_DEC);
      send_item(32'sh7FFF_FFFF, MODE_BIN);
      send_item(32'sh7FFF_FFFF, MODE_OCT);
      send_item(32'sh7FFF_FFFF, MODE_HEX);
      send_item(32'sh7FFF_FFFF, MODE_DEC);
      send_item(32'sh7FED_CBA9, MODE_HEX);
      send_item(32'sh0000_ABCD, MODE_HEX);
      send_item(15, MODE_HEX);
      send_item(16, MODE_HEX);
      send_item(7, MODE_OCT);
      send_item(8, MODE_OCT);
      send_item(9, MODE_DEC);
      send_item(10, MODE_DEC);
      send_item(1000000000, MODE_DEC);
      wait_drained();

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 24;
               recv_stall_pct = 82;
            end
            1: begin
               send_idle_pct = 82;
               recv_stall_pct = 24;
            end
            default: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
         endcase
         repeat (PHASE_ITEMS) begin
            send_random();
            if ($urandom_range(39) == 0)
               wait_drained();
         end
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0 && pending_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
